FILE: sv/rsfa_pkg.sv
// ---------------------------------------------------------------------------
// RAM and swap frame allocator package
// Shared constants, codes and transaction types for the frame allocator.
// ---------------------------------------------------------------------------
package rsfa_pkg;

	localparam int RAM_DEPTH  = 1024;
	localparam int SWAP_DEPTH = 4096;
	localparam int SLOT_COUNT = 128;
	localparam int OWNER_BITS = 12;

	localparam int TAG_W      = OWNER_BITS + 1;
	localparam int RAM_AW     = $clog2(RAM_DEPTH);
	localparam int SWAP_AW    = $clog2(SWAP_DEPTH);
	localparam int SLOT_AW    = $clog2(SLOT_COUNT);
	localparam int IDX_W      = SWAP_AW + 1;
	localparam int RAM_CNT_W  = 11;
	localparam int SWAP_CNT_W = 13;
	localparam int ACT_W      = 8;
	localparam int SEQ_W      = 32;
	localparam int PAGE_W     = 17;
	localparam int SIZE_W     = 8;
	localparam int DVD_W      = 19;
	localparam int CFG_IDX_W  = 2;

	localparam logic [1:0] CMD_CREATE      = 2'd0;
	localparam logic [1:0] CMD_KILL_SLOT   = 2'd1;
	localparam logic [1:0] CMD_KILL_OLDEST = 2'd2;
	localparam logic [1:0] CMD_UNUSED      = 2'd3;

	localparam logic [2:0] ST_CREATED    = 3'd0;
	localparam logic [2:0] ST_NO_SLOT    = 3'd1;
	localparam logic [2:0] ST_NO_MEMORY  = 3'd2;
	localparam logic [2:0] ST_TERMINATED = 3'd3;
	localparam logic [2:0] ST_NOTHING    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_RAM_FRAMES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SWAP_FRAMES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = 2'd2;

	typedef struct packed {
		logic [1:0]            cmd;
		logic [OWNER_BITS-1:0] owner_id;
		logic [SIZE_W-1:0]     size_mb;
		logic [6:0]            slot_index;
	} cmd_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [6:0]            slot_out;
		logic [RAM_CNT_W-1:0]  ram_frames_given;
		logic [SWAP_CNT_W-1:0] swap_frames_given;
		logic [RAM_CNT_W-1:0]  ram_used_out;
		logic [SWAP_CNT_W-1:0] swap_used_out;
		logic [ACT_W-1:0]      active_out;
	} rsp_t;

	typedef struct packed {
		logic [OWNER_BITS-1:0] owner;
		logic [RAM_CNT_W-1:0]  ram_cnt;
		logic [SWAP_CNT_W-1:0] swap_cnt;
		logic [SEQ_W-1:0]      birth;
	} slot_t;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [PAGE_W-1:0] divisor;
	} div_req_t;

endpackage

FILE: sv/ram_swap_frame_allocator_unit.sv
// ---------------------------------------------------------------------------
// RAM and swap frame allocator
// A create scans the 4096-entry swap map entry by entry twice, once to count
// free frames and once to claim them; a terminate scans it once, after a scan
// of the slot table when the oldest process is sought.
// One command is worked on at a time; the next may be accepted while the
// previous response waits. After reset a clearing pass over every entry
// empties both frame maps before the first command is accepted.
// ---------------------------------------------------------------------------
module ram_swap_frame_allocator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  rsfa_pkg::cmd_t                    cmd_data,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output rsfa_pkg::rsp_t                    rsp_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rsfa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rsfa_pkg::PAGE_W-1:0]       cfg_data
);
	import rsfa_pkg::*;

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_SLOT    = 4'd2;
	localparam logic [3:0] S_DIV     = 4'd3;
	localparam logic [3:0] S_COUNT   = 4'd4;
	localparam logic [3:0] S_CLAIM   = 4'd5;
	localparam logic [3:0] S_OLDEST  = 4'd6;
	localparam logic [3:0] S_READ    = 4'd7;
	localparam logic [3:0] S_RELEASE = 4'd8;
	localparam logic [3:0] S_DONE    = 4'd9;

	logic [3:0]            state_q;
	cmd_t                  cmd_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;
	logic [RAM_CNT_W-1:0]  ram_frames_q;
	logic [SWAP_CNT_W-1:0] swap_frames_q;
	logic [PAGE_W-1:0]     page_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      idx_s1;
	logic                  pv_s1;
	logic [SLOT_COUNT-1:0] slot_active_q;
	logic [SLOT_AW-1:0]    slot_q;
	logic [SLOT_AW-1:0]    best_q;
	logic [SEQ_W-1:0]      best_age_q;
	logic                  found_q;
	logic                  rd_wait_q;
	logic [RAM_CNT_W-1:0]  fr_q;
	logic [SWAP_CNT_W-1:0] fs_q;
	logic [RAM_CNT_W-1:0]  want_r_q;
	logic [SWAP_CNT_W-1:0] want_s_q;
	logic [TAG_W-1:0]      tag_q;
	logic [2:0]            res_status_q;
	logic [RAM_CNT_W-1:0]  res_ram_q;
	logic [SWAP_CNT_W-1:0] res_swap_q;
	logic [RAM_CNT_W-1:0]  ram_used_q;
	logic [SWAP_CNT_W-1:0] swap_used_q;
	logic [ACT_W-1:0]      active_cnt_q;
	logic [SEQ_W-1:0]      birth_q;

	logic                  scan_st;
	logic [IDX_W-1:0]      scan_end;
	logic                  issue;
	logic                  scan_done;
	logic [RAM_CNT_W-1:0]  rn;
	logic [SWAP_CNT_W-1:0] sn;
	logic                  ram_s1;
	logic                  ram_lim_s1;
	logic                  swap_lim_s1;
	logic [TAG_W-1:0]      ram_rd;
	logic [TAG_W-1:0]      swap_rd;
	logic                  ram_we;
	logic [RAM_AW-1:0]     ram_waddr;
	logic [TAG_W-1:0]      ram_wdata;
	logic                  swap_we;
	logic [SWAP_AW-1:0]    swap_waddr;
	logic [TAG_W-1:0]      swap_wdata;
	logic                  tbl_we;
	logic [SLOT_AW-1:0]    tbl_raddr;
	slot_t                 tbl_wdata;
	slot_t                 tbl_rd;
	logic [$bits(slot_t)-1:0] tbl_rd_raw;
	logic [SEQ_W-1:0]      age;
	logic [PAGE_W-1:0]     pg;
	div_req_t              div_req;
	logic                  div_done;
	logic [DVD_W-1:0]      pages;
	logic [RAM_CNT_W-1:0]  take_r;
	logic [DVD_W-1:0]      take_s;
	logic                  short_mem;

	assign rn = (ram_frames_q > RAM_CNT_W'(RAM_DEPTH)) ? RAM_CNT_W'(RAM_DEPTH) : ram_frames_q;
	assign sn = (swap_frames_q > SWAP_CNT_W'(SWAP_DEPTH)) ?
		SWAP_CNT_W'(SWAP_DEPTH) : swap_frames_q;

	assign scan_st  = (state_q == S_CLEAR) || (state_q == S_COUNT) || (state_q == S_CLAIM) ||
		(state_q == S_RELEASE) || (state_q == S_OLDEST);
	assign scan_end = (state_q == S_OLDEST) ? IDX_W'(SLOT_COUNT) : IDX_W'(SWAP_DEPTH);
	assign issue     = scan_st && (idx_q < scan_end);
	assign scan_done = !issue && !pv_s1;

	assign ram_s1      = pv_s1 && (idx_s1 < IDX_W'(RAM_DEPTH));
	assign ram_lim_s1  = pv_s1 && (idx_s1 < IDX_W'(rn));
	assign swap_lim_s1 = pv_s1 && (idx_s1 < IDX_W'(sn));

	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = idx_s1[RAM_AW-1:0];
		ram_wdata  = '0;
		swap_we    = 1'b0;
		swap_waddr = idx_s1[SWAP_AW-1:0];
		swap_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we     = issue && (idx_q < IDX_W'(RAM_DEPTH));
				ram_waddr  = idx_q[RAM_AW-1:0];
				swap_we    = issue;
				swap_waddr = idx_q[SWAP_AW-1:0];
			end
			S_CLAIM: begin
				ram_we     = ram_lim_s1 && !ram_rd[TAG_W-1] && (want_r_q != '0);
				ram_wdata  = tag_q;
				swap_we    = swap_lim_s1 && !swap_rd[TAG_W-1] && (want_s_q != '0);
				swap_wdata = tag_q;
			end
			S_RELEASE: begin
				ram_we  = ram_s1 && (ram_rd == tag_q);
				swap_we = pv_s1 && (swap_rd == tag_q);
			end
			default: begin
				ram_we  = 1'b0;
				swap_we = 1'b0;
			end
		endcase
	end

	rsfa_ram #(.DEPTH(RAM_DEPTH), .WIDTH(TAG_W)) u_ram_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q[RAM_AW-1:0]),
		.rdata (ram_rd)
	);

	rsfa_ram #(.DEPTH(SWAP_DEPTH), .WIDTH(TAG_W)) u_swap_map (
		.clk   (clk),
		.we    (swap_we),
		.waddr (swap_waddr),
		.wdata (swap_wdata),
		.raddr (idx_q[SWAP_AW-1:0]),
		.rdata (swap_rd)
	);

	assign tbl_we    = (state_q == S_CLAIM) && scan_done;
	assign tbl_raddr = (state_q == S_OLDEST) ? idx_q[SLOT_AW-1:0] : slot_q;
	assign tbl_wdata = '{owner: cmd_q.owner_id, ram_cnt: res_ram_q, swap_cnt: res_swap_q,
		birth: birth_q};
	assign tbl_rd    = slot_t'(tbl_rd_raw);
	assign age       = birth_q - tbl_rd.birth;

	rsfa_ram #(.DEPTH(SLOT_COUNT), .WIDTH($bits(slot_t))) u_slot_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (slot_q),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rd_raw)
	);

	assign pg               = (page_q == '0) ? PAGE_W'(1) : page_q;
	assign div_req.start    = (state_q == S_SLOT) && !slot_active_q[idx_q[SLOT_AW-1:0]];
	assign div_req.dividend = {1'b0, cmd_q.size_mb, 10'b0} + {2'b0, pg} - DVD_W'(1);
	assign div_req.divisor  = pg;

	rsfa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (pages)
	);

	assign take_r    = (pages > DVD_W'(fr_q)) ? fr_q : pages[RAM_CNT_W-1:0];
	assign take_s    = pages - DVD_W'(take_r);
	assign short_mem = take_s > DVD_W'(fs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			cmd_q         <= '0;
			rsp_q         <= '0;
			rsp_valid_q   <= 1'b0;
			ram_frames_q  <= RAM_CNT_W'(1024);
			swap_frames_q <= SWAP_CNT_W'(4096);
			page_q        <= PAGE_W'(4);
			idx_q         <= '0;
			idx_s1        <= '0;
			pv_s1         <= 1'b0;
			slot_active_q <= '0;
			slot_q        <= '0;
			best_q        <= '0;
			best_age_q    <= '0;
			found_q       <= 1'b0;
			rd_wait_q     <= 1'b0;
			fr_q          <= '0;
			fs_q          <= '0;
			want_r_q      <= '0;
			want_s_q      <= '0;
			tag_q         <= '0;
			res_status_q  <= ST_NOTHING;
			res_ram_q     <= '0;
			res_swap_q    <= '0;
			ram_used_q    <= '0;
			swap_used_q   <= '0;
			active_cnt_q  <= '0;
			birth_q       <= '0;
		end else begin
			pv_s1  <= issue;
			idx_s1 <= idx_q;
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cfg_valid) begin
				case (cfg_index)
					CFG_RAM_FRAMES:  ram_frames_q  <= cfg_data[RAM_CNT_W-1:0];
					CFG_SWAP_FRAMES: swap_frames_q <= cfg_data[SWAP_CNT_W-1:0];
					CFG_PAGE_SIZE:   page_q        <= cfg_data;
					default: begin
					end
				endcase
			end
			if (rsp_valid_q && !rsp_stall && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (scan_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q        <= cmd_data;
						idx_q        <= '0;
						found_q      <= 1'b0;
						fr_q         <= '0;
						fs_q         <= '0;
						res_status_q <= ST_NOTHING;
						res_ram_q    <= '0;
						res_swap_q   <= '0;
						slot_q       <= cmd_data.slot_index;
						case (cmd_data.cmd)
							CMD_CREATE: state_q <= S_SLOT;
							CMD_KILL_SLOT: begin
								if (slot_active_q[cmd_data.slot_index]) begin
									state_q <= S_READ;
								end else begin
									state_q <= S_DONE;
								end
							end
							CMD_KILL_OLDEST: state_q <= S_OLDEST;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SLOT: begin
					if (!slot_active_q[idx_q[SLOT_AW-1:0]]) begin
						slot_q  <= idx_q[SLOT_AW-1:0];
						state_q <= S_DIV;
					end else if (idx_q == IDX_W'(SLOT_COUNT - 1)) begin
						res_status_q <= ST_NO_SLOT;
						state_q      <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						idx_q   <= '0;
						state_q <= S_COUNT;
					end
				end
				S_COUNT: begin
					if (ram_lim_s1 && !ram_rd[TAG_W-1]) begin
						fr_q <= fr_q + 1'b1;
					end
					if (swap_lim_s1 && !swap_rd[TAG_W-1]) begin
						fs_q <= fs_q + 1'b1;
					end
					if (scan_done) begin
						if (short_mem) begin
							res_status_q <= ST_NO_MEMORY;
							state_q      <= S_DONE;
						end else begin
							want_r_q   <= take_r;
							want_s_q   <= take_s[SWAP_CNT_W-1:0];
							res_ram_q  <= take_r;
							res_swap_q <= take_s[SWAP_CNT_W-1:0];
							tag_q      <= {1'b1, cmd_q.owner_id};
							idx_q      <= '0;
							state_q    <= S_CLAIM;
						end
					end
				end
				S_CLAIM: begin
					if (ram_we) begin
						want_r_q <= want_r_q - 1'b1;
					end
					if (swap_we) begin
						want_s_q <= want_s_q - 1'b1;
					end
					if (scan_done) begin
						slot_active_q[slot_q] <= 1'b1;
						ram_used_q   <= ram_used_q + res_ram_q;
						swap_used_q  <= swap_used_q + res_swap_q;
						active_cnt_q <= active_cnt_q + 1'b1;
						birth_q      <= birth_q + 1'b1;
						res_status_q <= ST_CREATED;
						state_q      <= S_DONE;
					end
				end
				S_OLDEST: begin
					if (pv_s1 && slot_active_q[idx_s1[SLOT_AW-1:0]] &&
						(!found_q || (age > best_age_q))) begin
						found_q    <= 1'b1;
						best_q     <= idx_s1[SLOT_AW-1:0];
						best_age_q <= age;
					end
					if (scan_done) begin
						if (found_q) begin
							slot_q  <= best_q;
							state_q <= S_READ;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_READ: begin
					if (rd_wait_q) begin
						rd_wait_q    <= 1'b0;
						tag_q        <= {1'b1, tbl_rd.owner};
						res_ram_q    <= tbl_rd.ram_cnt;
						res_swap_q   <= tbl_rd.swap_cnt;
						res_status_q <= ST_TERMINATED;
						idx_q        <= '0;
						state_q      <= S_RELEASE;
					end else begin
						rd_wait_q <= 1'b1;
					end
				end
				S_RELEASE: begin
					if (ram_we && (ram_used_q != '0)) begin
						ram_used_q <= ram_used_q - 1'b1;
					end
					if (swap_we && (swap_used_q != '0)) begin
						swap_used_q <= swap_used_q - 1'b1;
					end
					if (scan_done) begin
						slot_active_q[slot_q] <= 1'b0;
						if (active_cnt_q != '0) begin
							active_cnt_q <= active_cnt_q - 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.status            <= res_status_q;
						rsp_q.slot_out          <= (res_status_q == ST_CREATED ||
							res_status_q == ST_TERMINATED) ? slot_q : '0;
						rsp_q.ram_frames_given  <= res_ram_q;
						rsp_q.swap_frames_given <= res_swap_q;
						rsp_q.ram_used_out      <= ram_used_q;
						rsp_q.swap_used_out     <= swap_used_q;
						rsp_q.active_out        <= active_cnt_q;
						rsp_valid_q             <= 1'b1;
						state_q                 <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign cfg_ready = 1'b1;

	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_cnt_q == ACT_W'($countones(slot_active_q)))
		else $error("Active process count disagrees with the slot table.");

	a_ram_used: assert property (@(posedge clk) disable iff (!arst_n)
		ram_used_q <= RAM_CNT_W'(RAM_DEPTH))
		else $error("RAM frames in use exceed the map depth.");

	a_swap_used: assert property (@(posedge clk) disable iff (!arst_n)
		swap_used_q <= SWAP_CNT_W'(SWAP_DEPTH))
		else $error("Swap frames in use exceed the map depth.");

	a_claim_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLAIM && scan_done) |-> (want_r_q == '0 && want_s_q == '0))
		else $error("A create transaction finished with frames still unclaimed.");

endmodule

FILE: sv/rsfa_ram.sv
// ---------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one registered read port.
// ---------------------------------------------------------------------------
module rsfa_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 13
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/rsfa_div.sv
// ---------------------------------------------------------------------------
// Page count divider
// Restoring divider that yields one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rsfa_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rsfa_pkg::div_req_t            req,
	output logic                          done,
	output logic [rsfa_pkg::DVD_W-1:0]    quotient
);
	import rsfa_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DVD_W-1:0]  quo_q;
	logic [PAGE_W-1:0] rem_q;
	logic [PAGE_W-1:0] dvs_q;
	logic [PAGE_W:0]   rem_sh;
	logic [PAGE_W:0]   diff;
	logic              ge;

	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
				quo_q  <= req.dividend;
				rem_q  <= '0;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= ge ? diff[PAGE_W-1:0] : rem_sh[PAGE_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], ge};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// Frame allocator testbench
// Drives create, terminate and unused commands into the allocator under several
// frame-count and page-size settings, predicts every response with a model
// of the frame maps and slot table, and checks each response field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import rsfa_pkg::*;

	localparam int CYCLE_LIMIT = 8_000_000;
	localparam int DRAIN_WAIT  = 9000;

	class alloc_scoreboard;
		logic [TAG_W-1:0]      ram_map[RAM_DEPTH];
		logic [TAG_W-1:0]      swap_map[SWAP_DEPTH];
		bit                    busy[SLOT_COUNT];
		logic [OWNER_BITS-1:0] owner_of[SLOT_COUNT];
		logic [RAM_CNT_W-1:0]  ram_of[SLOT_COUNT];
		logic [SWAP_CNT_W-1:0] swap_of[SLOT_COUNT];
		logic [SEQ_W-1:0]      born[SLOT_COUNT];
		int unsigned           ram_used, swap_used, live, births;
		int unsigned           ram_limit, swap_limit, page_kb;
		rsp_t                  due[$];
		bit                    failed;

		function new();
			foreach (ram_map[i]) ram_map[i] = '0;
			foreach (swap_map[i]) swap_map[i] = '0;
			foreach (busy[i]) busy[i] = 0;
			ram_used = 0; swap_used = 0; live = 0; births = 0;
			ram_limit = 1024; swap_limit = 4096; page_kb = 4;
			failed = 0;
		endfunction

		function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic [PAGE_W-1:0] val);
			case (idx)
				CFG_RAM_FRAMES: begin
					ram_limit = val[RAM_CNT_W-1:0];
				end
				CFG_SWAP_FRAMES: begin
					swap_limit = val[SWAP_CNT_W-1:0];
				end
				CFG_PAGE_SIZE: begin
					page_kb = val;
				end
				default: begin
				end
			endcase
		endfunction

		function int unsigned sub_floor(int unsigned a, int unsigned b);
			return a > b ? a - b : 0;
		endfunction

		function void kill(int s, ref rsp_t r);
			logic [TAG_W-1:0] tag;
			int unsigned      nr, ns;
			tag = {1'b1, owner_of[s]};
			nr = 0; ns = 0;
			foreach (ram_map[i]) if (ram_map[i] == tag) begin ram_map[i] = '0; nr++; end
			foreach (swap_map[i]) if (swap_map[i] == tag) begin swap_map[i] = '0; ns++; end
			ram_used = sub_floor(ram_used, nr);
			swap_used = sub_floor(swap_used, ns);
			busy[s] = 0;
			live = sub_floor(live, 1);
			r.status = ST_TERMINATED;
			r.slot_out = SLOT_AW'(s);
			r.ram_frames_given = ram_of[s];
			r.swap_frames_given = swap_of[s];
		endfunction

		function void note_cmd(cmd_t c);
			rsp_t        r;
			int          s, best;
			int unsigned pg, pages, rn, sn, fr, fs, take_r, take_s, want;
			logic [31:0] age, best_age;
			r = '0;
			r.status = ST_NOTHING;
			if (c.cmd == CMD_CREATE) begin
				s = -1;
				for (int i = 0; i < SLOT_COUNT; i++) if (!busy[i] && s < 0) s = i;
				if (s < 0) begin
					r.status = ST_NO_SLOT;
				end else begin
					pg = page_kb == 0 ? 1 : page_kb;
					pages = (c.size_mb * 1024 + pg - 1) / pg;
					rn = ram_limit > RAM_DEPTH ? RAM_DEPTH : ram_limit;
					sn = swap_limit > SWAP_DEPTH ? SWAP_DEPTH : swap_limit;
					fr = 0; fs = 0;
					for (int i = 0; i < rn; i++) if (!ram_map[i][OWNER_BITS]) fr++;
					for (int i = 0; i < sn; i++) if (!swap_map[i][OWNER_BITS]) fs++;
					take_r = fr < pages ? fr : pages;
					take_s = pages - take_r;
					if (take_s > fs) begin
						r.status = ST_NO_MEMORY;
					end else begin
						want = take_r;
						for (int i = 0; i < rn && want > 0; i++)
							if (!ram_map[i][OWNER_BITS]) begin
								ram_map[i] = {1'b1, c.owner_id}; want--;
							end
						want = take_s;
						for (int i = 0; i < sn && want > 0; i++)
							if (!swap_map[i][OWNER_BITS]) begin
								swap_map[i] = {1'b1, c.owner_id}; want--;
							end
						ram_used += take_r;
						swap_used += take_s;
						busy[s] = 1;
						owner_of[s] = c.owner_id;
						ram_of[s] = RAM_CNT_W'(take_r);
						swap_of[s] = SWAP_CNT_W'(take_s);
						born[s] = births;
						births++;
						live++;
						r.status = ST_CREATED;
						r.slot_out = SLOT_AW'(s);
						r.ram_frames_given = RAM_CNT_W'(take_r);
						r.swap_frames_given = SWAP_CNT_W'(take_s);
					end
				end
			end else if (c.cmd == CMD_KILL_SLOT) begin
				if (busy[c.slot_index]) kill(c.slot_index, r);
			end else if (c.cmd == CMD_KILL_OLDEST) begin
				best = -1;
				best_age = '0;
				for (int i = 0; i < SLOT_COUNT; i++)
					if (busy[i]) begin
						age = births - born[i];
						if (best < 0 || age > best_age) begin
							best = i; best_age = age;
						end
					end
				if (best >= 0) kill(best, r);
			end
			r.ram_used_out = RAM_CNT_W'(ram_used);
			r.swap_used_out = SWAP_CNT_W'(swap_used);
			r.active_out = ACT_W'(live);
			due.push_back(r);
		endfunction

		function void field(string name, int unsigned e, int unsigned a);
			if (e != a) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
				failed = 1;
			end
		endfunction

		function void check_rsp(rsp_t a);
			rsp_t e;
			if (due.size() == 0) begin
				$display("%0t: unexpected response %h", $time, a);
				failed = 1;
				return;
			end
			e = due.pop_front();
			field("status", e.status, a.status);
			field("slot_out", e.slot_out, a.slot_out);
			field("ram_frames_given", e.ram_frames_given, a.ram_frames_given);
			field("swap_frames_given", e.swap_frames_given, a.swap_frames_given);
			field("ram_used_out", e.ram_used_out, a.ram_used_out);
			field("swap_used_out", e.swap_used_out, a.swap_used_out);
			field("active_out", e.active_out, a.active_out);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cmd_valid;
	logic                 cmd_stall;
	cmd_t                 cmd_data;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PAGE_W-1:0]    cfg_data;

	alloc_scoreboard sb = new();
	bit              calm;
	int unsigned     rsp_count;
	int unsigned     cycles;

	ram_swap_frame_allocator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_data(cmd_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (calm || p < 70) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(20, 300);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sb.check_rsp(rsp_data);
			rsp_count <= rsp_count + 1;
		end
	end

	initial begin
		int  left;
		bit  held;
		left = 0;
		held = 0;
		forever begin
			@(negedge clk);
			if (!held && rsp_count == 10) begin
				held = 1;
				rsp_stall <= 1;
				repeat (30000) @(negedge clk);
			end
			if (left == 0) begin
				left = idle_len();
				rsp_stall <= left != 0;
			end else begin
				left--;
				rsp_stall <= left != 0;
			end
		end
	end

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [PAGE_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_cfg(idx, val);
		@(negedge clk);
	endtask

	task automatic settle_and_config(int unsigned ram, int unsigned swp, int unsigned pg);
		cmd_valid <= 0;
		while (sb.due.size() != 0) @(negedge clk);
		write_cfg(CFG_RAM_FRAMES, PAGE_W'(ram));
		write_cfg(CFG_SWAP_FRAMES, PAGE_W'(swp));
		write_cfg(CFG_PAGE_SIZE, PAGE_W'(pg));
		cfg_valid <= 0;
	endtask

	task automatic send_cmd(logic [1:0] op, logic [11:0] own, logic [7:0] sz, logic [6:0] si);
		cmd_t c;
		int   g;
		c.cmd = op;
		c.owner_id = own;
		c.size_mb = sz;
		c.slot_index = si;
		g = idle_len();
		if (g > 0) begin
			cmd_valid <= 0;
			repeat (g) @(negedge clk);
		end
		cmd_valid <= 1;
		cmd_data <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		sb.note_cmd(c);
		@(negedge clk);
	endtask

	task automatic random_phase(int n, int create_pct, int size_max);
		logic [1:0]  op;
		logic [11:0] own;
		logic [7:0]  sz;
		logic [6:0]  si;
		int          p;
		for (int k = 0; k < n; k++) begin
			p = $urandom_range(0, 99);
			if (p < create_pct) op = CMD_CREATE;
			else if (p < create_pct + (100 - create_pct) / 2) op = CMD_KILL_SLOT;
			else if ($urandom_range(0, 9) < 8) op = CMD_KILL_OLDEST;
			else op = CMD_UNUSED;
			own = OWNER_BITS'($urandom_range(0, 1) ? $urandom_range(0, 7) :
				$urandom_range(0, 4095));
			sz = SIZE_W'($urandom_range(0, 9) == 0 ? $urandom_range(0, 255) :
				$urandom_range(0, size_max));
			si = SLOT_AW'($urandom_range(0, 9) < 7 ? $urandom_range(0, 15) :
				$urandom_range(0, 127));
			send_cmd(op, own, sz, si);
		end
	endtask

	initial begin
		arst_n = 0;
		cmd_valid = 0;
		cmd_data = '0;
		rsp_stall = 1;
		cfg_valid = 0;
		cfg_index = CFG_RAM_FRAMES;
		cfg_data = '0;
		calm = 0;
		rsp_count = 0;
		cycles = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;

		settle_and_config(1024, 4096, 4);
		send_cmd(CMD_CREATE, 12'h000, 8'd1, 7'd0);
		send_cmd(CMD_CREATE, 12'hFFF, 8'd255, 7'd0);
		send_cmd(CMD_CREATE, 12'hFFF, 8'd0, 7'd127);
		send_cmd(CMD_CREATE, 12'h555, 8'd3, 7'd0);
		send_cmd(CMD_CREATE, 12'hAAA, 8'd2, 7'd0);
		send_cmd(CMD_CREATE, 12'h000, 8'd1, 7'd0);
		send_cmd(CMD_CREATE, 12'h123, 8'd16, 7'd0);
		send_cmd(CMD_KILL_SLOT, 12'h000, 8'd0, 7'd0);
		send_cmd(CMD_KILL_SLOT, 12'h000, 8'd0, 7'd127);
		send_cmd(CMD_KILL_SLOT, 12'h000, 8'd0, 7'd0);
		send_cmd(CMD_KILL_SLOT, 12'h000, 8'd0, 7'h55);
		send_cmd(CMD_UNUSED, 12'hFFF, 8'hFF, 7'h7F);
		send_cmd(CMD_KILL_SLOT, 12'h000, 8'd0, 7'd4);
		send_cmd(CMD_KILL_OLDEST, 12'h000, 8'd0, 7'h2A);
		send_cmd(CMD_KILL_OLDEST, 12'h000, 8'd0, 7'd0);
		send_cmd(CMD_KILL_OLDEST, 12'h000, 8'd0, 7'd0);
		send_cmd(CMD_KILL_OLDEST, 12'h000, 8'd0, 7'd0);
		send_cmd(CMD_KILL_OLDEST, 12'h000, 8'd0, 7'd0);

		settle_and_config(1, 0, 65536);
		send_cmd(CMD_CREATE, 12'h001, 8'd255, 7'd0);
		send_cmd(CMD_CREATE, 12'h002, 8'd64, 7'd0);
		send_cmd(CMD_CREATE, 12'h003, 8'd64, 7'd0);
		send_cmd(CMD_CREATE, 12'h004, 8'd128, 7'd0);
		random_phase(20, 50, 128);

		settle_and_config(1024, 4096, 64);
		random_phase(30, 55, 40);

		calm = 1;
		settle_and_config(2047, 8191, 0);
		random_phase(20, 50, 1);
		calm = 0;

		settle_and_config(37, 100, 256);
		random_phase(20, 50, 30);

		settle_and_config(1024, 4096, 65535);
		random_phase(20, 95, 255);
		random_phase(10, 0, 255);

		cmd_valid <= 0;
		while (sb.due.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (sb.failed || sb.due.size() != 0) begin
			$display("== FAIL ==");
		end else begin
			$display("== PASS ==");
		end
		$finish;
	end
endmodule

FILE: filelist.f
sv/rsfa_pkg.sv
sv/rsfa_ram.sv
sv/rsfa_div.sv
sv/ram_swap_frame_allocator_unit.sv
tb/tb_top.sv
